// File: src/ttfe_pkg.sv
`timescale 1ns / 1ps
package ttfe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DEN_W = 41;

  localparam logic [31:0] MIN_SPEED_SQ_RST = 32'd429497;
  localparam logic [31:0] LAT_THR_RST = 32'd655;
  localparam logic [15:0] QUAL_SCALE_RST = 16'd10000;

  typedef struct packed {
    logic               conf;
    logic [30:0]        spd;
    logic [30:0]        acc;
    logic signed [31:0] alt;
    logic signed [31:0] trace;
    logic [61:0]        spd2;
    logic               fast;
    logic               ovf;
  } ttfe_side_t;

  typedef struct packed {
    logic               conf;
    logic [30:0]        spd;
    logic [30:0]        acc;
    logic signed [31:0] alt;
    logic               straight;
    logic               rovf;
    logic [DEN_W-1:0]   den;
    logic               tz;
  } ttfe_rside_t;

  typedef struct packed {
    logic               conf;
    logic [30:0]        spd;
    logic [30:0]        acc;
    logic signed [31:0] alt;
    logic               straight;
    logic [31:0]        radius;
    logic               tz;
  } ttfe_qside_t;

  function automatic logic [63:0] mag_diff(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
    logic signed [64:0] d;
    logic [64:0] n;
    d = {a[63], a} - {b[63], b};
    n = -d;
    return d[64] ? n[63:0] : d[63:0];
  endfunction

endpackage

// File: src/ttfe_div.sv
`timescale 1ns / 1ps
module ttfe_div #(
  parameter int DW = 64,
  parameter int N  = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] d_in,
  input  logic [N-1:0]  num_in,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [N-1:0]  q_out,
  output logic [SW-1:0] side_out
);
  logic [DW-1:0] rem_r  [N];
  logic [DW-1:0] d_r    [N];
  logic [N-1:0]  num_r  [N];
  logic [N-1:0]  q_r    [N];
  logic [SW-1:0] side_r [N];
  logic          v_r    [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [DW-1:0] rem_p, d_p;
    logic [N-1:0]  num_p, q_p;
    logic [SW-1:0] side_p;
    logic          v_p, take;
    logic [DW:0]   trial, diff;
    if (i == 0) begin : g_first
      assign rem_p = rem_in;
      assign d_p = d_in;
      assign num_p = num_in;
      assign q_p = '0;
      assign side_p = side_in;
      assign v_p = v_in;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign d_p = d_r[i-1];
      assign num_p = num_r[i-1];
      assign q_p = q_r[i-1];
      assign side_p = side_r[i-1];
      assign v_p = v_r[i-1];
    end
    assign trial = {rem_p, num_p[N-1]};
    assign diff = trial - {1'b0, d_p};
    assign take = trial >= {1'b0, d_p};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
        d_r[i] <= d_p;
        num_r[i] <= {num_p[N-2:0], 1'b0};
        q_r[i] <= {q_p[N-2:0], take};
        side_r[i] <= side_p;
      end
    end
  end

  assign v_out = v_r[N-1];
  assign q_out = q_r[N-1];
  assign side_out = side_r[N-1];
endmodule

// File: src/ttfe_sqrt.sv
`timescale 1ns / 1ps
module ttfe_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [63:0]   x_in,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [31:0]   root_out,
  output logic [SW-1:0] side_out
);
  localparam int STEPS = 32;

  logic [63:0]   x_r    [STEPS];
  logic [63:0]   r_r    [STEPS];
  logic [SW-1:0] side_r [STEPS];
  logic          v_r    [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]   x_p, r_p, sum;
    logic [SW-1:0] side_p;
    logic          v_p, ge;
    if (k == 0) begin : g_first
      assign x_p = x_in;
      assign r_p = '0;
      assign side_p = side_in;
      assign v_p = v_in;
    end else begin : g_next
      assign x_p = x_r[k-1];
      assign r_p = r_r[k-1];
      assign side_p = side_r[k-1];
      assign v_p = v_r[k-1];
    end
    assign sum = r_p + BIT;
    assign ge = x_p >= sum;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= ge ? x_p - sum : x_p;
        r_r[k] <= ge ? (r_p >> 1) + BIT : r_p >> 1;
        side_r[k] <= side_p;
      end
    end
  end

  assign v_out = v_r[STEPS-1];
  assign root_out = r_r[STEPS-1][31:0];
  assign side_out = side_r[STEPS-1];
endmodule

// File: src/ttfe_front.sv
`timescale 1ns / 1ps
module ttfe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_in,
  input  logic                conf,
  input  logic signed [31:0]  vx,
  input  logic signed [31:0]  vy,
  input  logic signed [31:0]  vz,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  az,
  input  logic [30:0]         spd,
  input  logic [30:0]         acc,
  input  logic signed [31:0]  pos_h,
  input  logic signed [31:0]  plat_h,
  input  logic signed [31:0]  trace,
  input  logic [31:0]         min_speed_sq,
  output logic                v_out,
  output logic [63:0]         s_out,
  output logic [127:0]        c2_out,
  output ttfe_pkg::ttfe_side_t side_out
);
  import ttfe_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  ttfe_side_t         side1_r, side2_r, side3_r, side4_r, side5_r;
  logic [63:0]        sqx_r, sqy_r, sqz_r;
  logic signed [63:0] pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;
  logic [63:0]        s2_r, s3_r, s4_r, s5_r;
  logic [63:0]        c2m_r [3];
  logic [63:0]        pp_r  [3][4];
  logic [127:0]       sq4_r [3];
  logic [127:0]       c2_5_r;
  logic signed [32:0] alt_sum;
  logic signed [31:0] alt_sat;
  ttfe_side_t         side_nxt;
  ttfe_side_t         side2_f;

  assign alt_sum = {plat_h[31], plat_h} + {pos_h[31], pos_h};

  always_comb begin
    if (alt_sum[32] != alt_sum[31]) begin
      alt_sat = alt_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      alt_sat = alt_sum[31:0];
    end
    side_nxt = '0;
    side_nxt.conf = conf;
    side_nxt.spd = spd;
    side_nxt.acc = acc;
    side_nxt.alt = alt_sat;
    side_nxt.trace = trace;
    side_nxt.spd2 = spd * spd;
  end

  always_comb begin
    side2_f = side2_r;
    side2_f.fast = s2_r > {32'd0, min_speed_sq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      sqx_r <= vx * vx;
      sqy_r <= vy * vy;
      sqz_r <= vz * vz;
      pyz_r <= vy * az;
      pzy_r <= vz * ay;
      pzx_r <= vz * ax;
      pxz_r <= vx * az;
      pxy_r <= vx * ay;
      pyx_r <= vy * ax;

      side2_r <= side1_r;
      s2_r <= sqx_r + sqy_r + sqz_r;
      c2m_r[0] <= mag_diff(pyz_r, pzy_r);
      c2m_r[1] <= mag_diff(pzx_r, pxz_r);
      c2m_r[2] <= mag_diff(pxy_r, pyx_r);

      side3_r <= side2_f;
      s3_r <= s2_r;
      for (int j = 0; j < 3; j++) begin
        pp_r[j][0] <= c2m_r[j][31:0] * c2m_r[j][31:0];
        pp_r[j][1] <= c2m_r[j][31:0] * c2m_r[j][63:32];
        pp_r[j][2] <= c2m_r[j][63:32] * c2m_r[j][31:0];
        pp_r[j][3] <= c2m_r[j][63:32] * c2m_r[j][63:32];
      end

      side4_r <= side3_r;
      s4_r <= s3_r;
      for (int j = 0; j < 3; j++) begin
        sq4_r[j] <= (128'(pp_r[j][3]) << 64)
                  + ((128'(pp_r[j][1]) + 128'(pp_r[j][2])) << 32)
                  + 128'(pp_r[j][0]);
      end

      side5_r <= side4_r;
      s5_r <= s4_r;
      c2_5_r <= sq4_r[0] + sq4_r[1] + sq4_r[2];
    end
  end

  assign v_out = v5_r;
  assign s_out = s5_r;
  assign c2_out = c2_5_r;
  assign side_out = side5_r;
endmodule

// File: src/track_turn_feature_extract.sv
`timescale 1ns / 1ps
// Path of an accepted input word to its result word: the front products, then the
// 64-step divide of the squared cross product by the squared speed (the largest share
// of the latency), the 32-step square root, the 32-step radius divide, the quality divide.
// Throughput: one word per cycle; the whole pipeline stalls while a result waits.
// Reset (rst_n, synchronous): pipeline emptied, config registers take their defaults.
module track_turn_feature_extract #(
  parameter int FRAC_BITS = ttfe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_track_confirmed,
  input  logic signed [31:0] in_velocity_x,
  input  logic signed [31:0] in_velocity_y,
  input  logic signed [31:0] in_velocity_z,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_accel_z,
  input  logic [30:0]        in_track_speed,
  input  logic [30:0]        in_accel_magnitude,
  input  logic signed [31:0] in_position_height,
  input  logic signed [31:0] in_platform_height,
  input  logic signed [31:0] in_uncertainty_trace,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [30:0]        out_speed_out,
  output logic [30:0]        out_accel_out,
  output logic signed [31:0] out_altitude,
  output logic               out_straight,
  output logic [31:0]        out_turn_radius,
  output logic [15:0]        out_quality,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ttfe_pkg::*;

  localparam logic [1:0] REG_MIN_SPEED_SQ = 2'd0;
  localparam logic [1:0] REG_LAT_THR = 2'd1;
  localparam logic [1:0] REG_QUAL_SCALE = 2'd2;

  logic [31:0] min_speed_sq_r, lat_thr_r;
  logic [15:0] scale_r;
  logic        en, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_sq_r <= MIN_SPEED_SQ_RST;
      lat_thr_r <= LAT_THR_RST;
      scale_r <= QUAL_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MIN_SPEED_SQ: min_speed_sq_r <= pwdata;
        REG_LAT_THR: lat_thr_r <= pwdata;
        REG_QUAL_SCALE: scale_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_SPEED_SQ: prdata = min_speed_sq_r;
      REG_LAT_THR: prdata = lat_thr_r;
      REG_QUAL_SCALE: prdata = {16'd0, scale_r};
      default: prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  logic        f_v;
  logic [63:0] f_s;
  logic [127:0] f_c2;
  ttfe_side_t  f_side, d_side_in, d_side, s_side;

  ttfe_front u_front (
    .clk, .rst_n, .en,
    .v_in(in_valid && in_ready),
    .conf(in_track_confirmed),
    .vx(in_velocity_x), .vy(in_velocity_y), .vz(in_velocity_z),
    .ax(in_accel_x), .ay(in_accel_y), .az(in_accel_z),
    .spd(in_track_speed), .acc(in_accel_magnitude),
    .pos_h(in_position_height), .plat_h(in_platform_height),
    .trace(in_uncertainty_trace),
    .min_speed_sq(min_speed_sq_r),
    .v_out(f_v), .s_out(f_s), .c2_out(f_c2), .side_out(f_side)
  );

  always_comb begin
    d_side_in = f_side;
    d_side_in.ovf = f_c2[127:64] >= f_s;
  end

  logic        d_v;
  logic [63:0] d_q;
  logic [$bits(ttfe_side_t)-1:0] d_side_vec, s_side_vec;

  ttfe_div #(.DW(64), .N(64), .SW($bits(ttfe_side_t))) u_div_lat (
    .clk, .rst_n, .en,
    .v_in(f_v), .rem_in(f_c2[127:64]), .d_in(f_s), .num_in(f_c2[63:0]),
    .side_in(d_side_in),
    .v_out(d_v), .q_out(d_q), .side_out(d_side_vec)
  );
  assign d_side = d_side_vec;

  logic        s_v;
  logic [31:0] lat;

  ttfe_sqrt #(.SW($bits(ttfe_side_t))) u_sqrt (
    .clk, .rst_n, .en,
    .v_in(d_v), .x_in(d_side.ovf ? '1 : d_q), .side_in(d_side),
    .v_out(s_v), .root_out(lat), .side_out(s_side_vec)
  );
  assign s_side = s_side_vec;

  ttfe_rside_t r_side_in, r_side;
  logic [30:0] tcl;
  logic [DEN_W-1:0] scale_sh;

  assign tcl = s_side.trace[31] ? 31'd0 : s_side.trace[30:0];
  assign scale_sh = DEN_W'(scale_r) << FRAC_BITS;

  always_comb begin
    r_side_in.conf = s_side.conf;
    r_side_in.spd = s_side.spd;
    r_side_in.acc = s_side.acc;
    r_side_in.alt = s_side.alt;
    r_side_in.straight = !(s_side.fast && lat >= lat_thr_r);
    r_side_in.rovf = {2'b00, s_side.spd2[61:32]} >= lat;
    r_side_in.den = scale_sh + DEN_W'(tcl);
    r_side_in.tz = tcl == 31'd0;
  end

  logic        r_v;
  logic [31:0] r_q;
  logic [$bits(ttfe_rside_t)-1:0] r_side_vec;

  ttfe_div #(.DW(32), .N(32), .SW($bits(ttfe_rside_t))) u_div_rad (
    .clk, .rst_n, .en,
    .v_in(s_v), .rem_in({2'b00, s_side.spd2[61:32]}), .d_in(lat),
    .num_in(s_side.spd2[31:0]), .side_in(r_side_in),
    .v_out(r_v), .q_out(r_q), .side_out(r_side_vec)
  );
  assign r_side = r_side_vec;

  ttfe_qside_t q_side_in, q_side;

  always_comb begin
    q_side_in.conf = r_side.conf;
    q_side_in.spd = r_side.spd;
    q_side_in.acc = r_side.acc;
    q_side_in.alt = r_side.alt;
    q_side_in.straight = r_side.straight;
    q_side_in.radius = r_side.straight ? 32'd0 : (r_side.rovf ? '1 : r_q);
    q_side_in.tz = r_side.tz;
  end

  logic        q_v;
  logic [15:0] q_q;
  logic [$bits(ttfe_qside_t)-1:0] q_side_vec;

  ttfe_div #(.DW(DEN_W), .N(16), .SW($bits(ttfe_qside_t))) u_div_qual (
    .clk, .rst_n, .en,
    .v_in(r_v), .rem_in(scale_sh), .d_in(r_side.den), .num_in(16'd0),
    .side_in(q_side_in),
    .v_out(q_v), .q_out(q_q), .side_out(q_side_vec)
  );
  assign q_side = q_side_vec;

  logic        res_r, straight_r;
  logic [30:0] spd_r, acc_r;
  logic signed [31:0] alt_r;
  logic [31:0] radius_r;
  logic [15:0] quality_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= q_side.conf;
      spd_r <= q_side.conf ? q_side.spd : '0;
      acc_r <= q_side.conf ? q_side.acc : '0;
      alt_r <= q_side.conf ? q_side.alt : '0;
      straight_r <= q_side.conf && q_side.straight;
      radius_r <= q_side.conf ? q_side.radius : '0;
      if (!q_side.conf || scale_r == 16'd0) begin
        quality_r <= '0;
      end else begin
        quality_r <= q_side.tz ? 16'hFFFF : q_q;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_valid_res = res_r;
  assign out_speed_out = spd_r;
  assign out_accel_out = acc_r;
  assign out_altitude = alt_r;
  assign out_straight = straight_r;
  assign out_turn_radius = radius_r;
  assign out_quality = quality_r;
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ttfe_pkg::*;

  localparam logic [3:0] ADDR_MIN_SPEED_SQ = 4'd0;
  localparam logic [3:0] ADDR_LAT_THR = 4'd4;
  localparam logic [3:0] ADDR_QUAL_SCALE = 4'd8;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic               confirmed;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic [30:0]        spd;
    logic [30:0]        acc;
    logic signed [31:0] pos_h;
    logic signed [31:0] plat_h;
    logic signed [31:0] trace;
  } snapshot_t;

  typedef struct packed {
    logic               valid_res;
    logic [30:0]        speed;
    logic [30:0]        accel;
    logic signed [31:0] altitude;
    logic               straight;
    logic [31:0]        radius;
    logic [15:0]        quality;
  } features_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  snapshot_t in_word;
  features_t out_word;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  logic [31:0] min_speed_sq_q;
  logic [31:0] lat_thr_q;
  logic [15:0] qual_scale_q;

  features_t expected_features[$];
  int errors;
  bit in_idle_en;
  bit out_idle_en;

  track_turn_feature_extract uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_track_confirmed(in_word.confirmed),
    .in_velocity_x(in_word.vx), .in_velocity_y(in_word.vy), .in_velocity_z(in_word.vz),
    .in_accel_x(in_word.ax), .in_accel_y(in_word.ay), .in_accel_z(in_word.az),
    .in_track_speed(in_word.spd), .in_accel_magnitude(in_word.acc),
    .in_position_height(in_word.pos_h), .in_platform_height(in_word.plat_h),
    .in_uncertainty_trace(in_word.trace),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_valid_res(out_word.valid_res), .out_speed_out(out_word.speed),
    .out_accel_out(out_word.accel), .out_altitude(out_word.altitude),
    .out_straight(out_word.straight), .out_turn_radius(out_word.radius),
    .out_quality(out_word.quality),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [127:0] mag128(input logic signed [65:0] v);
    logic signed [65:0] n;
    n = -v;
    return v < 0 ? {62'd0, n} : {62'd0, v};
  endfunction

  function automatic features_t turn_features(input snapshot_t w);
    features_t f;
    logic signed [65:0] vx, vy, vz, ax, ay, az, sq, alt;
    logic [63:0] s, lat, spd, rad, num, den, q;
    logic [127:0] cx, cy, cz, c2, quo;
    f = '0;
    if (!w.confirmed) return f;
    vx = w.vx; vy = w.vy; vz = w.vz;
    ax = w.ax; ay = w.ay; az = w.az;
    alt = 66'(w.plat_h) + 66'(w.pos_h);
    if (alt > 66'sd2147483647) alt = 66'sd2147483647;
    if (alt < -66'sd2147483648) alt = -66'sd2147483648;
    f.valid_res = 1'b1;
    f.speed = w.spd;
    f.accel = w.acc;
    f.altitude = alt[31:0];
    f.straight = 1'b1;
    f.radius = 32'd0;
    sq = vx * vx + vy * vy + vz * vz;
    s = sq[63:0];
    if (s > {32'd0, min_speed_sq_q}) begin
      cx = mag128(vy * az - vz * ay);
      cy = mag128(vz * ax - vx * az);
      cz = mag128(vx * ay - vy * ax);
      c2 = cx * cx + cy * cy + cz * cz;
      quo = c2 / {64'd0, s};
      lat = root_floor(quo[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0]);
      if (lat >= {32'd0, lat_thr_q}) begin
        f.straight = 1'b0;
        if (lat == 0) begin
          f.radius = 32'hFFFF_FFFF;
        end else begin
          spd = {33'd0, w.spd};
          rad = (spd * spd) / lat;
          f.radius = rad > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : rad[31:0];
        end
      end
    end
    num = {16'd0, qual_scale_q, 32'd0};
    den = {32'd0, qual_scale_q, 16'd0} + (w.trace < 0 ? 64'd0 : {32'd0, w.trace});
    if (qual_scale_q == 0 || den == 0) begin
      f.quality = 16'd0;
    end else begin
      q = num / den;
      f.quality = q > 64'd65535 ? 16'hFFFF : q[15:0];
    end
    return f;
  endfunction

  always @(posedge clk) begin
    features_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_features.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = expected_features.pop_front();
        if (out_word.valid_res !== e.valid_res) begin
          $error("valid_res exp %0d got %0d", e.valid_res, out_word.valid_res); errors++;
        end
        if (out_word.speed !== e.speed) begin
          $error("speed_out exp %0d got %0d", e.speed, out_word.speed); errors++;
        end
        if (out_word.accel !== e.accel) begin
          $error("accel_out exp %0d got %0d", e.accel, out_word.accel); errors++;
        end
        if (out_word.altitude !== e.altitude) begin
          $error("altitude exp %0d got %0d", e.altitude, out_word.altitude); errors++;
        end
        if (out_word.straight !== e.straight) begin
          $error("straight exp %0d got %0d", e.straight, out_word.straight); errors++;
        end
        if (out_word.radius !== e.radius) begin
          $error("turn_radius exp %0d got %0d", e.radius, out_word.radius); errors++;
        end
        if (out_word.quality !== e.quality) begin
          $error("quality exp %0d got %0d", e.quality, out_word.quality); errors++;
        end
      end
    end
  end

  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = out_idle_en ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_snapshot(input snapshot_t w);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_features.push_back(turn_features(w));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_features.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      ADDR_MIN_SPEED_SQ: min_speed_sq_q = data;
      ADDR_LAT_THR: lat_thr_q = data;
      ADDR_QUAL_SCALE: qual_scale_q = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [3:0] addr, input logic [31:0] mask,
                           input logic [31:0] want);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (want & mask)) begin
      $error("prdata exp %0h got %0h", want & mask, prdata & mask);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] mss, input logic [31:0] lt,
                            input logic [15:0] qs);
    wait_idle();
    apb_write(ADDR_MIN_SPEED_SQ, mss);
    apb_write(ADDR_LAT_THR, lt);
    apb_write(ADDR_QUAL_SCALE, {16'd0, qs});
    apb_write(ADDR_UNUSED, $urandom);
    apb_check(ADDR_MIN_SPEED_SQ, 32'hFFFF_FFFF, min_speed_sq_q);
    apb_check(ADDR_LAT_THR, 32'hFFFF_FFFF, lat_thr_q);
    apb_check(ADDR_QUAL_SCALE, 32'h0000_FFFF, {16'd0, qual_scale_q});
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'(($urandom_range(0, 20000) - 10000) * 32'sd6554);
      4: return 32'($urandom_range(0, 131072) - 65536);
      default: return 32'(int'($urandom_range(0, 2000)) - 1000) << 12;
    endcase
  endfunction

  function automatic snapshot_t random_snapshot();
    snapshot_t w;
    w.confirmed = $urandom_range(0, 9) != 0;
    w.vx = pick_word(); w.vy = pick_word(); w.vz = pick_word();
    w.ax = pick_word(); w.ay = pick_word(); w.az = pick_word();
    w.spd = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h00FF_FFFF));
    w.acc = 31'($urandom);
    w.pos_h = pick_word(); w.plat_h = pick_word(); w.trace = pick_word();
    return w;
  endfunction

  function automatic snapshot_t make_snapshot(input logic c, input logic [31:0] v,
                                              input logic [31:0] a, input logic [31:0] t);
    snapshot_t w;
    w.confirmed = c;
    w.vx = v; w.vy = 32'sd0; w.vz = 32'sd0;
    w.ax = 32'sd0; w.ay = a; w.az = 32'sd0;
    w.spd = 31'd1 << 20; w.acc = 31'd12345;
    w.pos_h = 32'sd65536; w.plat_h = 32'sd655360; w.trace = t;
    return w;
  endfunction

  task automatic test_directed();
    snapshot_t w;
    in_idle_en = 1'b0; out_idle_en = 1'b0;
    w = '1; w.confirmed = 1'b0;
    send_snapshot(w);
    w = '1;
    send_snapshot(w);
    w = '0; w.confirmed = 1'b1;
    send_snapshot(w);
    w = '0; w.confirmed = 1'b1;
    w.vx = 32'h8000_0000; w.vy = 32'h8000_0000; w.vz = 32'h8000_0000;
    w.ax = 32'h7FFF_FFFF; w.ay = 32'h8000_0000; w.az = 32'h7FFF_FFFF;
    w.spd = 31'h7FFF_FFFF; w.acc = 31'h7FFF_FFFF;
    w.pos_h = 32'h7FFF_FFFF; w.plat_h = 32'h7FFF_FFFF; w.trace = 32'h7FFF_FFFF;
    send_snapshot(w);
    w.vx = 32'h7FFF_FFFF; w.ax = 32'h8000_0000;
    w.pos_h = 32'h8000_0000; w.plat_h = 32'h8000_0000; w.trace = 32'h8000_0000;
    send_snapshot(w);
    send_snapshot(make_snapshot(1'b1, 32'sd0, 32'sd65536, 32'sd0));
    send_snapshot(make_snapshot(1'b1, 32'sd655360, 32'sd0, -32'sd5));
    send_snapshot(make_snapshot(1'b1, 32'sd655360, 32'sd655360, 32'sd65536));
    send_snapshot(make_snapshot(1'b1, 32'sd655360, 32'sd600, 32'sd1000));
    send_snapshot(make_snapshot(1'b1, 32'sd655360, 32'sd655, 32'sd1000));
    send_snapshot(make_snapshot(1'b1, 32'sd1, 32'sd65536, 32'sd1000));
    send_snapshot(make_snapshot(1'b1, 32'sd2, 32'sd65536, 32'sd1000));
    w = make_snapshot(1'b1, 32'sd65536, 32'sd656, 32'sd0);
    w.spd = 31'h7FFF_FFFF;
    send_snapshot(w);
    w = make_snapshot(1'b1, 32'sd65536, 32'sd0, 32'sd0);
    w.ax = 32'sd65536;
    send_snapshot(w);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        in_idle_en = $urandom_range(0, 3) != 0;
        out_idle_en = $urandom_range(0, 3) != 0;
      end
      send_snapshot(random_snapshot());
    end
  endtask

  task automatic test_corner_config();
    set_config(32'd0, 32'd0, 16'd0);
    in_idle_en = 1'b1; out_idle_en = 1'b1;
    send_snapshot(make_snapshot(1'b1, 32'sd655360, 32'sd0, 32'sd0));
    send_snapshot(make_snapshot(1'b1, 32'sd1, 32'sd0, -32'sd1));
    send_snapshot(make_snapshot(1'b1, 32'sd0, 32'sd0, 32'sd100));
    test_random(120);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_snapshot(make_snapshot(1'b1, 32'sd65536, 32'sd655360, 32'sd0));
    test_random(120);
    set_config(32'd65536, 32'd6554, 16'd1);
    test_random(120);
    set_config($urandom, $urandom_range(0, 1 << 20), 16'($urandom_range(1, 65535)));
    test_random(120);
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_idle_en = 1'b0; out_idle_en = 1'b0;
    min_speed_sq_q = MIN_SPEED_SQ_RST;
    lat_thr_q = LAT_THR_RST;
    qual_scale_q = QUAL_SCALE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_corner_config();
    set_config(MIN_SPEED_SQ_RST, LAT_THR_RST, QUAL_SCALE_RST);
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
